### rtl/spq_pkg.sv
package spq_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int OCC_WIDTH        = 5;
   localparam int DEFAULT_CAPACITY = 16;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] removed_value;
      logic                          underflow;
      logic                          overflow;
      logic signed [VALUE_WIDTH-1:0] head_value;
      logic                          is_empty;
      logic [OCC_WIDTH-1:0]          occupancy;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

### rtl/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign busy     = (state_ff == ST_EXEC);
   assign cmd.load = start && !busy;
   assign cmd.exec = (state_ff == ST_EXEC);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/spq_datapath.sv
module spq_datapath
   import spq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_item,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_WIDTH-1:0] entry_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] entry_in [CAPACITY];
   logic [CNT_W-1:0]              count_ff, count_in;
   req_type                       req_ff;
   rsp_type                       rsp_ff, rsp_in;
   logic [CAPACITY-1:0]           lt;
   logic                          full;
   logic                          empty;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // each cell compares its own entry with the incoming value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (entry_ff[i] < req_ff.value);
      end
   end

   always_comb begin
      entry_in             = entry_ff;
      count_in             = count_ff;
      rsp_in.removed_value = '0;
      rsp_in.underflow     = 1'b0;
      rsp_in.overflow      = 1'b0;
      if (req_ff.func == FUNC_INSERT) begin
         if (full) begin
            rsp_in.overflow = 1'b1;
         end else begin
            // cells below the slot hold, the slot takes the value, cells above shift up
            if (!lt[0]) begin
               entry_in[0] = req_ff.value;
            end
            for (int i = 1; i < CAPACITY; i++) begin
               if (!lt[i]) begin
                  entry_in[i] = lt[i-1] ? req_ff.value : entry_ff[i-1];
               end
            end
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            rsp_in.underflow = 1'b1;
         end else begin
            rsp_in.removed_value = entry_ff[0];
            for (int i = 0; i < CAPACITY - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
            count_in = count_ff - 1'b1;
         end
      end
      rsp_in.is_empty   = (count_in == '0);
      rsp_in.head_value = (count_in == '0) ? '0 : entry_in[0];
      rsp_in.occupancy  = OCC_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.exec) begin
         entry_ff <= entry_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

### rtl/sorted_min_priority_queue_core.sv
// channel   ports                         transaction
// request   start, busy, req_item         taken when start is high and busy is low
// response  rsp_valid, rsp_item           one-cycle strobe, cannot be held off
//
// each request is first captured, then every cell of the sorted shift chain
// compares and moves in parallel; busy is high during that second step.
// the result strobes in the cycle after, when a new request may already be taken.
// reset clears the controller and the entry count; entries need no clearing.
// the receiver cannot stall, so nothing backs up behind a result.
module sorted_min_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not start execution");

   a_busy_then_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("execution did not produce exactly one response");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.underflow && rsp_item.overflow))
      else $error("underflow and overflow both set");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.is_empty |-> rsp_item.head_value == '0)
      else $error("empty queue shows a nonzero head");

endmodule

### bench/sorted_queue_checker.sv
`timescale 1ns / 1ps

module sorted_queue_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      mismatch_count,
   output int      pending_count
);

   logic signed [VALUE_WIDTH-1:0] model_entries [CAPACITY];
   int                            model_count = 0;
   rsp_type                       predicted_results [$];
   int                            error_total = 0;

   // applies one operation to the shadow queue and returns the result it should give
   function automatic rsp_type predict_queue_step(req_type op);
      rsp_type                       r;
      int                            pos;
      int                            i;
      logic signed [VALUE_WIDTH-1:0] v;
      r = '0;
      v = op.value;
      if (op.func == FUNC_INSERT) begin
         if (model_count >= CAPACITY) begin
            r.overflow = 1'b1;
         end else begin
            pos = 0;
            while (pos < model_count && model_entries[pos] < v) pos++;
            for (i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
            model_entries[pos] = v;
            model_count++;
         end
      end else begin
         if (model_count == 0) begin
            r.underflow = 1'b1;
         end else begin
            r.removed_value = model_entries[0];
            for (i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
            model_count--;
         end
      end
      r.head_value = (model_count > 0) ? model_entries[0] : '0;
      r.is_empty   = (model_count == 0);
      r.occupancy  = OCC_WIDTH'(model_count);
      return r;
   endfunction

   function automatic void check_field(string field, logic [VALUE_WIDTH-1:0] want,
                                       logic [VALUE_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         error_total++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         model_count = 0;
         predicted_results.delete();
      end else begin
         // retire the result first so a transaction taken at this edge queues behind it
         if (rsp_valid) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_item);
               error_total++;
            end else begin
               want = predicted_results.pop_front();
               check_field("removed_value", want.removed_value, rsp_item.removed_value);
               check_field("underflow", VALUE_WIDTH'(want.underflow),
                           VALUE_WIDTH'(rsp_item.underflow));
               check_field("overflow", VALUE_WIDTH'(want.overflow),
                           VALUE_WIDTH'(rsp_item.overflow));
               check_field("head_value", want.head_value, rsp_item.head_value);
               check_field("is_empty", VALUE_WIDTH'(want.is_empty),
                           VALUE_WIDTH'(rsp_item.is_empty));
               check_field("occupancy", VALUE_WIDTH'(want.occupancy),
                           VALUE_WIDTH'(rsp_item.occupancy));
            end
         end
         if (start && !busy) predicted_results.push_back(predict_queue_step(req_item));
      end
      mismatch_count <= error_total;
      pending_count  <= predicted_results.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 1550;
   localparam int STALL_LIMIT  = 4000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      mismatch_count;
   int      pending_count;
   int      burst_left;
   int      sent_count;
   int      op_bias;
   int      run_length;

   logic signed [VALUE_WIDTH-1:0] fill_values [16] = '{
      32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
      32'sh00000001, 32'sh7fffffff, 32'sh80000000, 32'sh00000005,
      32'shfffffffb, 32'sh00000064, 32'shffffff9c, 32'sh40000000,
      32'shc0000000, 32'sh55555555, 32'shaaaaaaaa, 32'sh00000000
   };

   always #6 clock = ~clock;

   sorted_min_priority_queue_core #(.CAPACITY(CAPACITY)) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   sorted_queue_checker #(.CAPACITY(CAPACITY)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   function automatic req_type make_op(logic func, logic signed [VALUE_WIDTH-1:0] value);
      req_type r;
      r.func  = func;
      r.value = value;
      return r;
   endfunction

   // extremes and tight ranges are weighted up so duplicates and sign edges show up often
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      logic signed [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = 32'sh00000000;
               3: v = 32'shffffffff;
               default: v = 32'sh00000001;
            endcase
         end
         1: v = $signed($urandom_range(0, 8)) - 4;
         2: v = 32'sh7fffffff - $signed($urandom_range(0, 3));
         3: v = 32'sh80000000 + $signed($urandom_range(0, 3));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic req_type random_op(int insert_pct);
      return make_op(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
                     pick_value());
   endfunction

   // returns at the edge where the transaction is taken
   task automatic send_op(req_type op);
      start    <= 1'b1;
      req_item <= op;
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 80);
         end else begin
            burst_left = $urandom_range(1, 12);
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // remove on empty, fill to capacity with extremes and duplicates, insert on full, then remove twice
      send_op(make_op(FUNC_REMOVE, 32'sh12345678));
      for (int i = 0; i < 16; i++) send_op(make_op(FUNC_INSERT, fill_values[i]));
      send_op(make_op(FUNC_INSERT, 32'sh00000000));
      send_op(make_op(FUNC_REMOVE, 32'shffffffff));
      send_op(make_op(FUNC_REMOVE, 32'sh00000000));
      wait_drained();

      burst_left = 1;
      sent_count = 0;
      while (sent_count < RANDOM_ITEMS) begin
         // biased runs push the queue to full and to empty, mixed runs wander in between
         case ($urandom_range(0, 4))
            0: op_bias = 85;
            1: op_bias = 15;
            2: op_bias = 50;
            3: op_bias = 65;
            default: op_bias = 35;
         endcase
         run_length = $urandom_range(20, 100);
         for (int j = 0; j < run_length && sent_count < RANDOM_ITEMS; j++) begin
            send_op(random_op(op_bias));
            sent_count++;
            if (sent_count % 400 == 0) begin
               wait_drained();
               burst_left = 1;
            end else begin
               pace_sender();
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_min_priority_queue_core.sv
bench/sorted_queue_checker.sv
bench/tb_top.sv
